FILE: design/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg : shared types and constants for the distance-vector route table
// Field widths, mode codes, the classified command and its operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

	// default node count
	localparam int NODES_DEF = 16;

	// field widths
	localparam int MODE_W = 2;
	localparam int NODE_W = 4;
	localparam int DIST_W = 9;
	localparam int HOP_W  = 5;
	localparam int CNT_W  = 5;

	// mode codes on the input beat
	localparam logic [MODE_W-1:0] MODE_LINK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ADV   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

	// distance and hop codes
	localparam logic [DIST_W-1:0] DIST_UNREACH = 9'h1FF;
	localparam logic [DIST_W-1:0] DIST_ZERO    = 9'h000;
	localparam logic [DIST_W-1:0] DIST_ONE     = 9'h001;
	localparam logic [DIST_W-2:0] DIST_SAT     = 8'hFF;
	localparam logic [HOP_W-1:0]  HOP_NONE     = 5'h1F;
	localparam logic [CNT_W-1:0]  CNT_SAT      = 5'h1F;

	// operation after classification
	typedef enum logic [2:0] {
		OP_NOP,
		OP_MISS,
		OP_LINK,
		OP_BUILD,
		OP_ADV,
		OP_READ
	} op_t;

	// command passed from front to back
	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} cmd_t;

endpackage

`default_nettype wire

FILE: design/drt_ram.sv
// ----------------------------------------------------------------------------
// drt_ram : generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front : input side of the route table
// Accepts beats, checks node range, turns each into a command and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_front #(
	parameter int NODES = drt_pkg::NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [drt_pkg::MODE_W-1:0]  mode,
	input  wire logic [drt_pkg::NODE_W-1:0]  node_a,
	input  wire logic [drt_pkg::NODE_W-1:0]  node_b,
	output logic                             cmd_valid,
	output drt_pkg::cmd_t                    cmd,
	input  wire logic                        cmd_pop
);

	localparam logic [1:0] QDEPTH = 2'd2;

	drt_pkg::cmd_t cmd_new;
	logic          nodes_ok;
	logic          push;
	logic          pop;

	drt_pkg::cmd_t cmd_mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	// classify the incoming beat
	always_comb begin
		nodes_ok = (32'(node_a) < NODES) && (32'(node_b) < NODES);
		cmd_new.node_a = node_a;
		cmd_new.node_b = node_b;
		unique case (mode)
			drt_pkg::MODE_LINK:  cmd_new.op = nodes_ok ? drt_pkg::OP_LINK : drt_pkg::OP_NOP;
			drt_pkg::MODE_BUILD: cmd_new.op = drt_pkg::OP_BUILD;
			drt_pkg::MODE_ADV:   cmd_new.op = nodes_ok ? drt_pkg::OP_ADV : drt_pkg::OP_NOP;
			drt_pkg::MODE_READ:  cmd_new.op = nodes_ok ? drt_pkg::OP_READ : drt_pkg::OP_MISS;
			default:             cmd_new.op = drt_pkg::OP_NOP;
		endcase
	end

	assign in_ready  = (count_q != QDEPTH);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = cmd_mem_q[rd_ptr_q];

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				cmd_mem_q[wr_ptr_q] <= cmd_new;
				wr_ptr_q            <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back : execution side of the route table
// Runs one command at a time against the link and route memories and holds
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_back #(
	parameter int NODES = drt_pkg::NODES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_valid,
	input  wire drt_pkg::cmd_t                      cmd,
	output logic                                    cmd_pop,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [drt_pkg::DIST_W-1:0]       distance,
	output logic signed [drt_pkg::HOP_W-1:0]        via_node,
	output logic        [drt_pkg::CNT_W-1:0]        entries_changed
);

	localparam int DIST_W = drt_pkg::DIST_W;
	localparam int HOP_W  = drt_pkg::HOP_W;
	localparam int CNT_W  = drt_pkg::CNT_W;
	localparam int ROW_W  = $clog2(NODES);
	localparam int RA_W   = 2 * ROW_W;
	localparam int RDEPTH = NODES << ROW_W;
	localparam int ENT_W  = DIST_W + HOP_W;
	localparam logic [ROW_W-1:0] LAST = ROW_W'(NODES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LINK,
		S_ADV_CHK,
		S_ADV_RUN,
		S_BLD_RD,
		S_BLD_WR,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  row_a_q;
	logic [ROW_W-1:0]  row_b_q;
	logic [ROW_W-1:0]  col_q;
	logic [ROW_W-1:0]  col_s1;
	logic              vld_s1;
	logic              iss_q;
	logic              a_ok_q;
	logic              b_ok_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NODES-1:0]  link_valid_q;
	logic [NODES-1:0]  route_valid_q;
	logic [DIST_W-1:0] res_dist_q;
	logic [HOP_W-1:0]  res_hop_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic [HOP_W-1:0]  out_hop_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic [ROW_W-1:0]  cmd_row_a;
	logic [ROW_W-1:0]  cmd_row_b;

	logic [ROW_W-1:0]  lnk_raddr;
	logic [NODES-1:0]  lnk_rdata;
	logic [NODES-1:0]  lnk_row;
	logic              lnk_we;
	logic [NODES-1:0]  lnk_wdata;

	logic [RA_W-1:0]   rta_raddr;
	logic [RA_W-1:0]   rtb_raddr;
	logic [ENT_W-1:0]  rta_rdata;
	logic [ENT_W-1:0]  rtb_rdata;
	logic              rt_we;
	logic [RA_W-1:0]   rt_waddr;
	logic [ENT_W-1:0]  rt_wdata;

	logic [DIST_W-1:0] da;
	logic [DIST_W-1:0] db;
	logic [HOP_W-1:0]  ha;
	logic [HOP_W-1:0]  hb;
	logic              da_pos;
	logic [DIST_W-2:0] cand;
	logic              upd;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [ENT_W-1:0]  bld_ent;

	assign cmd_row_a = ROW_W'(cmd.node_a);
	assign cmd_row_b = ROW_W'(cmd.node_b);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	// link map memory, one row of link bits per source node
	assign lnk_raddr = (state_q == S_IDLE) ? cmd_row_a : row_a_q;
	assign lnk_row   = link_valid_q[row_a_q] ? lnk_rdata : '0;
	assign lnk_we    = (state_q == S_LINK);
	assign lnk_wdata = lnk_row | (NODES'(1) << row_b_q);

	drt_ram #(
		.WIDTH (NODES),
		.DEPTH (NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (row_a_q),
		.wdata (lnk_wdata),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	// route table held twice so sender and receiver rows read together
	assign rta_raddr = (state_q == S_IDLE) ? {cmd_row_a, cmd_row_b} : {row_a_q, col_q};
	assign rtb_raddr = {row_b_q, col_q};

	drt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RDEPTH)
	) u_route_ram_a (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (rta_raddr),
		.rdata (rta_rdata)
	);

	drt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RDEPTH)
	) u_route_ram_b (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (rtb_raddr),
		.rdata (rtb_rdata)
	);

	// entries of rows never written read as unreachable
	always_comb begin
		da = a_ok_q ? rta_rdata[ENT_W-1 -: DIST_W] : drt_pkg::DIST_UNREACH;
		ha = a_ok_q ? rta_rdata[HOP_W-1:0] : drt_pkg::HOP_NONE;
		db = b_ok_q ? rtb_rdata[ENT_W-1 -: DIST_W] : drt_pkg::DIST_UNREACH;
		hb = b_ok_q ? rtb_rdata[HOP_W-1:0] : drt_pkg::HOP_NONE;
	end

	// relaxation of one receiver entry
	always_comb begin
		da_pos  = !da[DIST_W-1] && (da != drt_pkg::DIST_ZERO);
		cand    = (da[DIST_W-2:0] == drt_pkg::DIST_SAT) ? drt_pkg::DIST_SAT
		                                                 : da[DIST_W-2:0] + 1'b1;
		upd     = vld_s1 && da_pos && (col_s1 != row_b_q)
		          && (db[DIST_W-1] || (cand < db[DIST_W-2:0]));
		cnt_nxt = (upd && (cnt_q != drt_pkg::CNT_SAT)) ? cnt_q + 1'b1 : cnt_q;
	end

	// entry written by the table build
	always_comb begin
		if (col_q == row_a_q) begin
			bld_ent = {drt_pkg::DIST_ZERO, HOP_W'(row_a_q)};
		end else if (lnk_row[col_q]) begin
			bld_ent = {drt_pkg::DIST_ONE, HOP_W'(col_q)};
		end else begin
			bld_ent = {drt_pkg::DIST_UNREACH, drt_pkg::HOP_NONE};
		end
	end

	// shared write port of both route copies
	always_comb begin
		rt_we = (state_q == S_BLD_WR) || ((state_q == S_ADV_RUN) && vld_s1);
		if (state_q == S_BLD_WR) begin
			rt_waddr = {row_a_q, col_q};
			rt_wdata = bld_ent;
		end else begin
			rt_waddr = {row_b_q, col_s1};
			rt_wdata = upd ? {1'b0, cand, HOP_W'(row_a_q)} : {db, hb};
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_a_q       <= '0;
			row_b_q       <= '0;
			col_q         <= '0;
			col_s1        <= '0;
			vld_s1        <= 1'b0;
			iss_q         <= 1'b0;
			a_ok_q        <= 1'b0;
			b_ok_q        <= 1'b0;
			cnt_q         <= '0;
			link_valid_q  <= '0;
			route_valid_q <= '0;
			res_dist_q    <= '0;
			res_hop_q     <= '0;
			res_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			out_dist_q    <= '0;
			out_hop_q     <= '0;
			out_cnt_q     <= '0;
		end else begin
			// result taken; a waiting result reloads it from the done state
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						row_a_q    <= (cmd.op == drt_pkg::OP_BUILD) ? '0 : cmd_row_a;
						row_b_q    <= cmd_row_b;
						col_q      <= '0;
						a_ok_q     <= route_valid_q[cmd_row_a];
						b_ok_q     <= route_valid_q[cmd_row_b];
						res_dist_q <= (cmd.op == drt_pkg::OP_MISS) ? drt_pkg::DIST_UNREACH
						                                           : drt_pkg::DIST_ZERO;
						res_hop_q  <= drt_pkg::HOP_NONE;
						res_cnt_q  <= '0;
						case (cmd.op)
							drt_pkg::OP_MISS:  state_q <= S_DONE;
							drt_pkg::OP_READ:  state_q <= S_READ;
							drt_pkg::OP_LINK:  state_q <= S_LINK;
							drt_pkg::OP_ADV:   state_q <= S_ADV_CHK;
							drt_pkg::OP_BUILD: state_q <= S_BLD_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					res_dist_q <= da;
					res_hop_q  <= ha;
					state_q    <= S_DONE;
				end
				S_LINK: begin
					link_valid_q[row_a_q] <= 1'b1;
					state_q               <= S_DONE;
				end
				S_ADV_CHK: begin
					if (lnk_row[row_b_q]) begin
						iss_q   <= 1'b1;
						vld_s1  <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_ADV_RUN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADV_RUN: begin
					vld_s1 <= iss_q;
					col_s1 <= col_q;
					cnt_q  <= cnt_nxt;
					if (iss_q) begin
						if (col_q == LAST) begin
							iss_q <= 1'b0;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
					if (vld_s1 && (col_s1 == LAST)) begin
						route_valid_q[row_b_q] <= 1'b1;
						res_cnt_q              <= cnt_nxt;
						state_q                <= S_DONE;
					end
				end
				S_BLD_RD: begin
					state_q <= S_BLD_WR;
				end
				S_BLD_WR: begin
					if (col_q == LAST) begin
						col_q                  <= '0;
						route_valid_q[row_a_q] <= 1'b1;
						if (row_a_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							row_a_q <= row_a_q + 1'b1;
							state_q <= S_BLD_RD;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_dist_q  <= res_dist_q;
						out_hop_q   <= res_hop_q;
						out_cnt_q   <= res_cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign distance        = out_dist_q;
	assign via_node        = out_hop_q;
	assign entries_changed = out_cnt_q;

endmodule

`default_nettype wire

FILE: design/distance_vector_route_table.sv
// One command runs at a time in the back end, walking a table row one entry
// per cycle over its route memory ports; an advertise with no link ends
// without a row walk. A two-entry queue keeps taking beats meanwhile until
// it is full. Reset clears the link and route row valid bits at once, so the
// block is ready as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
// distance_vector_route_table : top level
// Link map and hop-count routing table with add, build, advertise and read.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table #(
	parameter int NODES = drt_pkg::NODES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [drt_pkg::MODE_W-1:0]    mode,
	input  wire logic [drt_pkg::NODE_W-1:0]    node_a,
	input  wire logic [drt_pkg::NODE_W-1:0]    node_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [drt_pkg::DIST_W-1:0]  distance,
	output logic signed [drt_pkg::HOP_W-1:0]   via_node,
	output logic        [drt_pkg::CNT_W-1:0]   entries_changed
);

	logic          cmd_valid;
	logic          cmd_pop;
	drt_pkg::cmd_t cmd;

	// beat intake and command queue
	drt_front #(
		.NODES (NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.node_a    (node_a),
		.node_b    (node_b),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// table engine and result register
	drt_back #(
		.NODES (NODES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance        (distance),
		.via_node        (via_node),
		.entries_changed (entries_changed)
	);

endmodule

`default_nettype wire

FILE: test/distance_vector_route_table_tb.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_tb : self-checking bench for the route table
// Drives add link, build, advertise and read beats. A route predictor keeps
// its own link map and table and works out the result of each accepted beat.
// Every result beat is checked field by field against the oldest prediction.
// Both sides idle at random but in the last part, and there is one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_table_tb;

	localparam int N = drt_pkg::NODES_DEF;
	localparam int NW = drt_pkg::NODE_W;
	localparam int MW = drt_pkg::MODE_W;
	localparam int LONG_HOLD = 300;

	// one predicted result beat
	typedef struct {
		logic signed [drt_pkg::DIST_W-1:0] hops;
		logic signed [drt_pkg::HOP_W-1:0]  hop;
		logic        [drt_pkg::CNT_W-1:0]  changed;
	} route_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [MW-1:0]                      mode;
	logic [NW-1:0]                      node_a;
	logic [NW-1:0]                      node_b;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [drt_pkg::DIST_W-1:0]  distance;
	logic signed [drt_pkg::HOP_W-1:0]   via_node;
	logic        [drt_pkg::CNT_W-1:0]   entries_changed;

	// predictor state
	bit link_net   [N][N];
	int route_dist [N][N];
	int route_via  [N][N];

	route_result_t route_expect[$];
	int            fail_count;
	bit            quiet;
	bit            hold_req;

	distance_vector_route_table #(
		.NODES(N)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.node_a          (node_a),
		.node_b          (node_b),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance        (distance),
		.via_node        (via_node),
		.entries_changed (entries_changed)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// random node number
	function automatic logic [NW-1:0] rnd_node();
		return NW'($urandom_range(0, N - 1));
	endfunction

	// route predictor: applies one beat and returns its result
	function automatic route_result_t route_step(input logic [MW-1:0] op,
			input logic [NW-1:0] a, input logic [NW-1:0] b);
		route_result_t r;
		int cand;
		int cnt;
		r.hops    = drt_pkg::DIST_ZERO;
		r.hop     = drt_pkg::HOP_NONE;
		r.changed = '0;
		case (op)
		drt_pkg::MODE_LINK: begin
			link_net[a][b] = 1'b1;
		end
		drt_pkg::MODE_BUILD: begin
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++) begin
					if (i == j) begin
						route_dist[i][j] = 0;
						route_via[i][j]  = i;
					end else if (link_net[i][j]) begin
						route_dist[i][j] = 1;
						route_via[i][j]  = j;
					end else begin
						route_dist[i][j] = -1;
						route_via[i][j]  = -1;
					end
				end
			end
		end
		drt_pkg::MODE_ADV: begin
			// relax the receiver row from the sender row, only over a real link
			if (link_net[a][b]) begin
				cnt = 0;
				for (int i = 0; i < N; i++) begin
					if (route_dist[a][i] > 0 && i != b) begin
						cand = route_dist[a][i] + 1;
						if (cand > 255)
							cand = 255;
						if (route_dist[b][i] == -1 || cand < route_dist[b][i]) begin
							route_dist[b][i] = cand;
							route_via[b][i]  = a;
							cnt++;
						end
					end
				end
				r.changed = (cnt > 31) ? drt_pkg::CNT_SAT : drt_pkg::CNT_W'(cnt);
			end
		end
		drt_pkg::MODE_READ: begin
			r.hops = drt_pkg::DIST_W'(route_dist[a][b]);
			r.hop  = drt_pkg::HOP_W'(route_via[a][b]);
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	// offer one beat, wait for acceptance, record the prediction
	task automatic send_command(input logic [MW-1:0] m, input logic [NW-1:0] a,
			input logic [NW-1:0] b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid = 1'b1;
		mode     = m;
		node_a   = a;
		node_b   = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		route_expect.push_back(route_step(m, a, b));
		@(negedge clk);
	endtask

	// hold the input side until every predicted beat has come back
	task automatic drain_results();
		in_valid = 1'b0;
		while (route_expect.size() != 0)
			@(negedge clk);
	endtask

	// reads, and advertise with no links, straight after reset
	task automatic test_reset_state();
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd0);
		send_command(drt_pkg::MODE_READ, 4'd15, 4'd15);
		send_command(drt_pkg::MODE_READ, 4'd15, 4'd0);
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd15);
		send_command(drt_pkg::MODE_ADV, 4'd0, 4'd1);
		send_command(drt_pkg::MODE_ADV, 4'd15, 4'd15);
	endtask

	// small hand-built graph: build, relaxation, self advertise, missing link
	task automatic test_directed_routes();
		send_command(drt_pkg::MODE_LINK, 4'd0, 4'd1);
		send_command(drt_pkg::MODE_LINK, 4'd1, 4'd2);
		send_command(drt_pkg::MODE_LINK, 4'd1, 4'd0);
		send_command(drt_pkg::MODE_LINK, 4'd0, 4'd15);
		send_command(drt_pkg::MODE_LINK, 4'd15, 4'd15);
		send_command(drt_pkg::MODE_LINK, 4'd15, 4'd0);
		send_command(drt_pkg::MODE_BUILD, 4'd15, 4'd0);
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd0);
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd1);
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd2);
		send_command(drt_pkg::MODE_READ, 4'd15, 4'd15);
		send_command(drt_pkg::MODE_ADV, 4'd1, 4'd0);
		send_command(drt_pkg::MODE_ADV, 4'd0, 4'd15);
		send_command(drt_pkg::MODE_ADV, 4'd15, 4'd15);
		send_command(drt_pkg::MODE_ADV, 4'd2, 4'd1);
		send_command(drt_pkg::MODE_READ, 4'd15, 4'd2);
		send_command(drt_pkg::MODE_READ, 4'd0, 4'd2);
		drain_results();
	endtask

	// long output hold-off while beats keep coming, so the input stalls
	task automatic test_output_stall();
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		for (int k = 0; k < 10; k++)
			send_command(drt_pkg::MODE_READ, NW'(k), NW'(N - 1 - k));
		drain_results();
	endtask

	// rounds of new links, rebuild, advertise along links and reads
	task automatic test_random_routes(input int items);
		int sent;
		int a;
		int b;
		int tries;
		sent = 0;
		while (sent < items) begin
			// a few new links
			repeat ($urandom_range(0, 2)) begin
				send_command(drt_pkg::MODE_LINK, rnd_node(), rnd_node());
				sent++;
			end
			// rebuild most rounds, sometimes advertise on a stale table
			if ($urandom_range(0, 3) != 0) begin
				send_command(drt_pkg::MODE_BUILD, rnd_node(), rnd_node());
				sent++;
			end
			// advertise mostly over existing links, each followed by a read
			repeat ($urandom_range(6, 14)) begin
				a = $urandom_range(0, N - 1);
				b = $urandom_range(0, N - 1);
				tries = 0;
				if ($urandom_range(0, 7) != 0) begin
					while (!link_net[a][b] && tries < 64) begin
						a = $urandom_range(0, N - 1);
						b = $urandom_range(0, N - 1);
						tries++;
					end
				end
				send_command(drt_pkg::MODE_ADV, NW'(a), NW'(b));
				send_command(drt_pkg::MODE_READ, NW'(b), rnd_node());
				sent += 2;
			end
			// loose reads, and the odd beat of any mode
			repeat ($urandom_range(2, 6)) begin
				send_command(drt_pkg::MODE_READ, rnd_node(), rnd_node());
				sent++;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_command(MW'($urandom_range(0, 3)), rnd_node(), rnd_node());
				sent++;
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end
	endtask

	// result side: random ready bursts plus the long hold-off on request
	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				out_ready = 1'b0;
				idle_left--;
			end else begin
				out_ready = 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					idle_left = $urandom_range(1, 19);
			end
		end
	end

	// result checker
	initial begin
		route_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (route_expect.size() == 0) begin
					$display("%0t: unexpected result beat: distance %0d via_node %0d",
						$time, distance, via_node);
					fail_count++;
				end else begin
					want = route_expect.pop_front();
					if (distance !== want.hops) begin
						$display("%0t: distance expected %0d actual %0d",
							$time, want.hops, distance);
						fail_count++;
					end
					if (via_node !== want.hop) begin
						$display("%0t: via_node expected %0d actual %0d",
							$time, want.hop, via_node);
						fail_count++;
					end
					if (entries_changed !== want.changed) begin
						$display("%0t: entries_changed expected %0d actual %0d",
							$time, want.changed, entries_changed);
						fail_count++;
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

	// main sequence
	initial begin
		fail_count = 0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = drt_pkg::MODE_LINK;
		node_a     = '0;
		node_b     = '0;
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				link_net[i][j]   = 1'b0;
				route_dist[i][j] = -1;
				route_via[i][j]  = -1;
			end
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed_routes();
		test_output_stall();
		test_random_routes(1000);
		drain_results();
		// last part with no idling on either side
		@(posedge clk);
		quiet = 1'b1;
		@(negedge clk);
		test_random_routes(80);

		drain_results();
		repeat (N * (N + 1) + 8) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: distance_vector_route_table.f
design/drt_pkg.sv
design/drt_ram.sv
design/drt_front.sv
design/drt_back.sv
design/distance_vector_route_table.sv
test/distance_vector_route_table_tb.sv
